[hdl/sip_pkg.sv]
`timescale 1ns / 1ps

package sip_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned PosWidth   = 32;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a_start_x;
    logic signed [CoordWidth-1:0] a_start_y;
    logic signed [CoordWidth-1:0] a_end_x;
    logic signed [CoordWidth-1:0] a_end_y;
    logic signed [CoordWidth-1:0] b_start_x;
    logic signed [CoordWidth-1:0] b_start_y;
    logic signed [CoordWidth-1:0] b_end_x;
    logic signed [CoordWidth-1:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic                       degenerate;
    logic signed [PosWidth-1:0] position;
  } out_item_t;

  // Widths of the intermediate values: differences, products, sums,
  // and the numerator and denominator handed to the divider.
  localparam int unsigned DiffWidth = CoordWidth + 1;
  localparam int unsigned ProdWidth = 2 * DiffWidth;
  localparam int unsigned SumWidth  = ProdWidth + 1;
  localparam int unsigned NumWidth  = SumWidth + 1;

  localparam logic [PosWidth-1:0] PosLimit = {1'b0, {(PosWidth-1){1'b1}}};
  localparam logic [PosWidth-1:0] NegLimit = {1'b1, {(PosWidth-1){1'b0}}};

endpackage

[hdl/segment_intersection_position_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Payload                  Handshake
// in        input      sip_pkg::in_item_t       in_valid_i / in_stall_o
// out       output     sip_pkg::out_item_t      out_valid_o / out_stall_i
//
// One transaction enters per cycle while in_stall_o is low; results pass
// through the 32-step pipelined restoring divider into the result register.
// Reset clears only the valid bits of the pipeline and of the skid register.
// A stalled result moves into a skid register and the pipeline freezes
// while that register is full; no transaction is lost or repeated.
module segment_intersection_position_core #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sip_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sip_pkg::out_item_t  out_data_o
);

  localparam int unsigned DW = sip_pkg::DiffWidth;
  localparam int unsigned PW = sip_pkg::ProdWidth;
  localparam int unsigned SW = sip_pkg::SumWidth;
  localparam int unsigned NW = sip_pkg::NumWidth;
  localparam int unsigned QW = sip_pkg::PosWidth;
  localparam int unsigned SH = QW - FRACTION_BITS;
  localparam int unsigned XW = NW + FRACTION_BITS;

  logic adv;
  logic skid_valid_q, skid_valid_d;
  sip_pkg::out_item_t skid_q;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Stage 1: differences.
  logic v1_q;
  logic signed [DW-1:0] dx1_q, dy1_q, dx2_q, dy2_q, px_q, py_q, qx_q, qy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q <= DW'(in_data_i.a_end_x) - DW'(in_data_i.a_start_x);
      dy1_q <= DW'(in_data_i.a_end_y) - DW'(in_data_i.a_start_y);
      dx2_q <= DW'(in_data_i.b_end_x) - DW'(in_data_i.b_start_x);
      dy2_q <= DW'(in_data_i.b_end_y) - DW'(in_data_i.b_start_y);
      px_q  <= DW'(in_data_i.a_start_x) - DW'(in_data_i.b_start_x);
      py_q  <= DW'(in_data_i.a_start_y) - DW'(in_data_i.b_start_y);
      qx_q  <= DW'(in_data_i.b_end_x) - DW'(in_data_i.a_start_x);
      qy_q  <= DW'(in_data_i.b_end_y) - DW'(in_data_i.a_start_y);
    end
  end

  // Stage 2: products.
  logic v2_q;
  logic signed [PW-1:0] m_xx_q, m_yy_q, m_d1_q, m_d2_q, m_t1_q, m_t2_q;
  logic signed [PW-1:0] m_s1_q, m_s2_q, m_n1a_q, m_n1b_q, m_n2a_q, m_n2b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_xx_q  <= PW'(dx1_q) * PW'(dx1_q);
      m_yy_q  <= PW'(dy1_q) * PW'(dy1_q);
      m_d1_q  <= PW'(dy2_q) * PW'(dx1_q);
      m_d2_q  <= PW'(dx2_q) * PW'(dy1_q);
      m_t1_q  <= PW'(dx2_q) * PW'(py_q);
      m_t2_q  <= PW'(dy2_q) * PW'(px_q);
      m_s1_q  <= PW'(dx1_q) * PW'(py_q);
      m_s2_q  <= PW'(dy1_q) * PW'(px_q);
      m_n1a_q <= PW'(dx1_q) * PW'(px_q);
      m_n1b_q <= PW'(dy1_q) * PW'(py_q);
      m_n2a_q <= PW'(dx1_q) * PW'(qx_q);
      m_n2b_q <= PW'(dy1_q) * PW'(qy_q);
    end
  end

  // Stage 3: cross products, squared length and projections.
  logic v3_q;
  logic signed [SW-1:0] len2_q, d_q, t_q, s_q, n1_q, n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len2_q <= SW'(m_xx_q) + SW'(m_yy_q);
      d_q    <= SW'(m_d1_q) - SW'(m_d2_q);
      t_q    <= SW'(m_t1_q) - SW'(m_t2_q);
      s_q    <= SW'(m_s1_q) - SW'(m_s2_q);
      n1_q   <= -(SW'(m_n1a_q) + SW'(m_n1b_q));
      n2_q   <= SW'(m_n2a_q) + SW'(m_n2b_q);
    end
  end

  // Stage 4: classification flags.
  logic v4_q;
  logic degen4_q, colin4_q, cross4_q, encl4_q, in1_4_q, in2_4_q;
  logic signed [SW-1:0] len2_4_q, d4_q, t4_q, n1_4_q, n2_4_q;
  logic t_in, s_in;

  always_comb begin
    if (d_q > 0) begin
      t_in = (t_q >= 0) && (t_q <= d_q);
      s_in = (s_q >= 0) && (s_q <= d_q);
    end else begin
      t_in = (t_q <= 0) && (t_q >= d_q);
      s_in = (s_q <= 0) && (s_q >= d_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      degen4_q <= (len2_q == '0);
      colin4_q <= (d_q == '0) && (s_q == '0);
      cross4_q <= (d_q != '0) && t_in && s_in;
      encl4_q  <= ((n1_q <= 0) && (n2_q >= len2_q)) || ((n2_q <= 0) && (n1_q >= len2_q));
      in1_4_q  <= (n1_q >= 0) && (n1_q <= len2_q);
      in2_4_q  <= (n2_q >= 0) && (n2_q <= len2_q);
      len2_4_q <= len2_q;
      d4_q     <= d_q;
      t4_q     <= t_q;
      n1_4_q   <= n1_q;
      n2_4_q   <= n2_q;
    end
  end

  // Stage 5: pick numerator and denominator. The half-way case divides
  // one by two, which yields exactly one half.
  logic v5_q;
  logic found5_q, degen5_q;
  logic signed [NW-1:0] num5_q, den5_q;
  logic found_c;
  logic signed [NW-1:0] num_c, den_c, len2x2, outside;

  always_comb begin
    len2x2  = NW'(len2_4_q) + NW'(len2_4_q);
    outside = in1_4_q ? NW'(n2_4_q) : NW'(n1_4_q);
    found_c = 1'b0;
    num_c   = '0;
    den_c   = NW'(1);
    if (degen4_q) begin
      found_c = 1'b0;
    end else if (colin4_q) begin
      found_c = 1'b1;
      if (encl4_q) begin
        num_c = NW'(1);
        den_c = NW'(2);
      end else if (in1_4_q && in2_4_q) begin
        num_c = NW'(n1_4_q) + NW'(n2_4_q);
        den_c = len2x2;
      end else if (in1_4_q || in2_4_q) begin
        num_c = (outside < 0) ? outside : outside + NW'(len2_4_q);
        den_c = len2x2;
      end else begin
        found_c = 1'b0;
      end
    end else if (cross4_q) begin
      found_c = 1'b1;
      num_c   = NW'(t4_q);
      den_c   = NW'(d4_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      found5_q <= found_c;
      degen5_q <= degen4_q;
      num5_q   <= num_c;
      den5_q   <= den_c;
    end
  end

  // Stage 6: magnitudes, saturation check and divider start.
  typedef struct packed {
    logic          found;
    logic          degen;
    logic          neg;
    logic          sat;
    logic [NW-1:0] den;
    logic [NW-1:0] rem;
    logic [QW-1:0] dividend;
    logic [QW-1:0] quo;
  } div_stage_t;

  logic          dv_q [0:QW];
  div_stage_t    ds_q [0:QW];
  logic [NW-1:0] n_mag, d_mag, n_top;
  logic [XW-1:0] n_wide;

  always_comb begin
    n_mag  = num5_q[NW-1] ? NW'(-num5_q) : NW'(num5_q);
    d_mag  = den5_q[NW-1] ? NW'(-den5_q) : NW'(den5_q);
    n_top  = n_mag >> SH;
    n_wide = {n_mag, {FRACTION_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ds_q[0].found    <= found5_q;
      ds_q[0].degen    <= degen5_q;
      ds_q[0].neg      <= num5_q[NW-1] ^ den5_q[NW-1];
      ds_q[0].sat      <= (n_top >= d_mag);
      ds_q[0].den      <= d_mag;
      ds_q[0].rem      <= n_top;
      ds_q[0].dividend <= n_wide[QW-1:0];
      ds_q[0].quo      <= '0;
    end
  end

  // Divider: one quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW:0] rem_sh;
    logic        ge;
    div_stage_t  stage_d;

    always_comb begin
      rem_sh      = {ds_q[k].rem, ds_q[k].dividend[QW-1-k]};
      ge          = (rem_sh >= {1'b0, ds_q[k].den});
      stage_d     = ds_q[k];
      stage_d.rem = ge ? NW'(rem_sh - {1'b0, ds_q[k].den}) : NW'(rem_sh);
      stage_d.quo = {ds_q[k].quo[QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ds_q[k+1] <= stage_d;
      end
    end
  end

  // Final stage: clamp, sign and result register.
  logic               fin_v_q;
  sip_pkg::out_item_t fin_q;
  logic [QW-1:0]      lim, mag;

  always_comb begin
    lim = ds_q[QW].neg ? sip_pkg::NegLimit : sip_pkg::PosLimit;
    mag = (ds_q[QW].sat || (ds_q[QW].quo > lim)) ? lim : ds_q[QW].quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (adv) begin
      fin_v_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_q.found      <= ds_q[QW].found;
      fin_q.degenerate <= ds_q[QW].degen;
      fin_q.position   <= ds_q[QW].neg ? -mag : mag;
    end
  end

  // Skid register catches the shown result when the pipeline moves on
  // while the downstream side stalls.
  always_comb begin
    skid_valid_d = skid_valid_q;
    if (skid_valid_q && !out_stall_i) begin
      skid_valid_d = 1'b0;
    end else if (!skid_valid_q && fin_v_q && out_stall_i) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      skid_q <= fin_q;
    end
  end

  assign out_valid_o = skid_valid_q || fin_v_q;
  assign out_data_o  = skid_valid_q ? skid_q : fin_q;

`ifndef SYNTHESIS
  a_skid_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_o)
    else $error("skid register full without a valid result");

  a_degen_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.found && out_data_o.degenerate))
    else $error("degenerate result flagged as found");

  a_zero_when_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.position == '0))
    else $error("nonzero position without an intersection");
`endif

endmodule

[test/segment_intersection_position_checker.sv]
`timescale 1ns / 1ps

module segment_intersection_position_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sip_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sip_pkg::out_item_t out_data_i,
  output int                 mismatch_count_o,
  output int                 pending_count_o
);

  localparam int FracBits = 16;

  sip_pkg::out_item_t expected_q[$];

  // Fixed-point quotient, truncated toward zero and saturated to 32 bits.
  function automatic logic signed [31:0] fixed_quotient(longint num, longint den);
    logic neg;
    longint unsigned n, dd, lim, ip, rem, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    dd = (den < 0) ? -den : den;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (n == 0) return '0;
    ip = n / dd;
    rem = n % dd;
    if (ip > (lim >> FracBits)) return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    q = (ip << FracBits) + ((rem << FracBits) / dd);
    if (q > lim) q = lim;
    return neg ? -q : q;
  endfunction

  function automatic logic within_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  function automatic sip_pkg::out_item_t intersection_position(sip_pkg::in_item_t it);
    sip_pkg::out_item_t r;
    longint ax1, ay1, bx1, by1, dx1, dy1, dx2, dy2, px, py, d, t, s, len2, n1, n2, o;
    logic in1, in2;
    ax1 = it.a_start_x; ay1 = it.a_start_y;
    bx1 = it.b_start_x; by1 = it.b_start_y;
    dx1 = longint'(it.a_end_x) - ax1; dy1 = longint'(it.a_end_y) - ay1;
    dx2 = longint'(it.b_end_x) - bx1; dy2 = longint'(it.b_end_y) - by1;
    px = ax1 - bx1; py = ay1 - by1;
    r = '0;
    len2 = dx1 * dx1 + dy1 * dy1;
    if (len2 == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    d = dy2 * dx1 - dx2 * dy1;
    t = dx2 * py - dy2 * px;
    s = dx1 * py - dy1 * px;
    if (d == 0 && s == 0) begin
      n1 = dx1 * (bx1 - ax1) + dy1 * (by1 - ay1);
      n2 = dx1 * (longint'(it.b_end_x) - ax1) + dy1 * (longint'(it.b_end_y) - ay1);
      in1 = n1 >= 0 && n1 <= len2;
      in2 = n2 >= 0 && n2 <= len2;
      r.found = 1'b1;
      if ((n1 <= 0 && n2 >= len2) || (n2 <= 0 && n1 >= len2)) begin
        r.position = 32'sd1 <<< (FracBits - 1);
      end else if (in1 && in2) begin
        r.position = fixed_quotient(n1 + n2, 2 * len2);
      end else if (in1 || in2) begin
        o = in1 ? n2 : n1;
        r.position = (o < 0) ? fixed_quotient(o, 2 * len2)
                             : fixed_quotient(o + len2, 2 * len2);
      end else begin
        r.found = 1'b0;
      end
    end else if (d != 0 && within_unit(t, d) && within_unit(s, d)) begin
      r.found = 1'b1;
      r.position = fixed_quotient(t, d);
    end
    return r;
  endfunction

  initial mismatch_count_o = 0;
  assign pending_count_o = expected_q.size();

  always @(posedge clk_i) begin
    sip_pkg::out_item_t exp_item;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(intersection_position(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatch_count_o <= mismatch_count_o + 1;
          if (mismatch_count_o < 10) $display("unexpected result %p", out_data_i);
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data_i.found !== exp_item.found
              || out_data_i.degenerate !== exp_item.degenerate
              || out_data_i.position !== exp_item.position) begin
            mismatch_count_o <= mismatch_count_o + 1;
            if (mismatch_count_o < 10)
              $display("mismatch: expected %p actual %p", exp_item, out_data_i);
          end
        end
      end
    end
  end

endmodule

[test/segment_intersection_position_core_test.sv]
`timescale 1ns / 1ps

module segment_intersection_position_core_test;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sip_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sip_pkg::out_item_t out_data;
  int                 mismatch_count;
  int                 pending_count;
  logic               stimulus_done = 1'b0;

  always #1 clk = ~clk;

  segment_intersection_position_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  segment_intersection_position_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_count)
  );

  function automatic logic signed [15:0] any_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function automatic logic signed [15:0] clip(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Shapes that reach the collinear, crossing and degenerate cases often.
  function automatic sip_pkg::in_item_t random_pair();
    sip_pkg::in_item_t it;
    int kind;
    longint k1, k2, dx, dy;
    kind = $urandom_range(0, 9);
    it = {any_coord(), any_coord(), any_coord(), any_coord(),
          any_coord(), any_coord(), any_coord(), any_coord()};
    if (kind < 4) begin
      dx = $signed($urandom_range(0, 200)) - 100;
      dy = $signed($urandom_range(0, 200)) - 100;
      k1 = $signed($urandom_range(0, 60)) - 20;
      k2 = $signed($urandom_range(0, 60)) - 20;
      it.a_start_x = clip($signed($urandom_range(0, 2000)) - 1000);
      it.a_start_y = clip($signed($urandom_range(0, 2000)) - 1000);
      it.a_end_x = clip(it.a_start_x + 20 * dx);
      it.a_end_y = clip(it.a_start_y + 20 * dy);
      it.b_start_x = clip(it.a_start_x + k1 * dx);
      it.b_start_y = clip(it.a_start_y + k1 * dy);
      it.b_end_x = clip(it.a_start_x + k2 * dx);
      it.b_end_y = clip(it.a_start_y + k2 * dy);
    end else if (kind < 7) begin
      it.b_start_x = -it.a_start_x + 16'($signed($urandom_range(0, 8)) - 4);
      it.b_end_x = -it.a_end_x;
      it.b_start_y = it.a_end_y;
      it.b_end_y = it.a_start_y;
    end else if (kind == 7) begin
      it.a_end_x = it.a_start_x;
      it.a_end_y = it.a_start_y;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high so that transactions can follow back to back.
  task automatic send_pair(sip_pkg::in_item_t it);
    int idle;
    idle = $urandom_range(0, 16) * $urandom_range(0, 1);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    sip_pkg::in_item_t dir_q[$];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    dir_q.push_back('{0, 0, 10, 0, 5, -5, 5, 5});
    dir_q.push_back('{0, 0, 10, 0, 0, -5, 0, 5});
    dir_q.push_back('{0, 0, 10, 0, 10, 5, 10, -5});
    dir_q.push_back('{0, 0, 10, 0, 11, 5, 11, -5});
    dir_q.push_back('{0, 0, 10, 0, 0, 1, 10, 1});
    dir_q.push_back('{0, 0, 10, 0, -5, 0, 15, 0});
    dir_q.push_back('{0, 0, 10, 0, 2, 0, 7, 0});
    dir_q.push_back('{0, 0, 10, 0, -4, 0, 3, 0});
    dir_q.push_back('{0, 0, 10, 0, 14, 0, 6, 0});
    dir_q.push_back('{0, 0, 10, 0, 12, 0, 15, 0});
    dir_q.push_back('{0, 0, 10, 0, 4, 0, 4, 0});
    dir_q.push_back('{0, 0, 10, 0, 4, 3, 4, 3});
    dir_q.push_back('{3, 3, 3, 3, 0, 0, 9, 9});
    dir_q.push_back('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768});
    dir_q.push_back('{32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767});
    dir_q.push_back('{0, 0, 1, 0, -32768, 0, 32767, 0});
    dir_q.push_back('{-32768, 0, 32767, 0, -32768, 0, 32767, 0});
    dir_q.push_back('{0, 0, 1, 1, 32767, 32767, 32767, 32767});
    dir_q.push_back('{0, 0, 1, 0, 0, 32767, 1, -32768});
    foreach (dir_q[i]) send_pair(dir_q[i]);
    in_valid <= 1'b0;
    // Drain completely once before the random traffic.
    wait (pending_count == 0);
    @(negedge clk);
    for (int n = 0; n < 1800; n++) send_pair(random_pair());
    in_valid <= 1'b0;
    stimulus_done <= 1'b1;
  end

  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    wait (pending_count == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("segment_intersection_position_core_test passed");
    end else begin
      $display("segment_intersection_position_core_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("segment_intersection_position_core_test failed");
    $finish;
  end

endmodule

[segment_intersection_position_core.f]
hdl/sip_pkg.sv
hdl/segment_intersection_position_core.sv
test/segment_intersection_position_checker.sv
test/segment_intersection_position_core_test.sv
